/* design/plat_pkg.sv */
package plat_pkg;

   // Fixed point format
   localparam int FRAC_BITS = 16;
   localparam int LANES     = 3;

   // Field widths
   localparam int CW   = 32;              // coordinate / velocity
   localparam int DTW  = 31;              // time step, unsigned
   localparam int DW   = CW + 1;          // start-relative vectors
   localparam int PW   = 2 * DW;          // signed 33x33 product
   localparam int DOTW = PW + 2;          // dot product, signed
   localparam int LENW = PW;              // squared length, unsigned
   localparam int TRW  = LENW + 1;        // projection divider remainder
   localparam int TW   = FRAC_BITS + 1;   // projection parameter 0..ONE
   localparam int FPW  = DW + TW + 1;     // d * t product
   localparam int RW   = DW + 1;          // offset to closest point, signed
   localparam int RMW  = RW - 1;          // its magnitude
   localparam int R2W  = 2 * RMW + 2;     // squared distance
   localparam int SQW  = R2W / 2;         // distance
   localparam int SRW  = SQW + 2;         // square root remainder
   localparam int NRW  = SQW + 1;         // direction divider remainder
   localparam int UW   = FRAC_BITS + 2;   // unit direction, signed
   localparam int APW  = UW + CW;         // u * strength product
   localparam int AW   = CW + 1;          // acceleration, signed
   localparam int DPW  = AW + DTW + 1;    // a * dt product
   localparam int DELW = DPW - FRAC_BITS; // velocity increment
   localparam int SUMW = DELW + 1;        // velocity plus increment

   localparam logic [TW-1:0] T_ONE = {1'b1, {FRAC_BITS{1'b0}}};

   // 0.1 rounded to the format, and its square for the distance test
   localparam longint THRESH = ((longint'(1) << FRAC_BITS) + 5) / 10;
   localparam logic [R2W-1:0] TH2 = R2W'(THRESH * THRESH);

   // Iterative units: steps per register stage
   localparam int DIVT_PER  = 4;
   localparam int DIVT_ST   = (FRAC_BITS + DIVT_PER - 1) / DIVT_PER;
   localparam int SQ_PER    = 4;
   localparam int SQ_ST     = (SQW + SQ_PER - 1) / SQ_PER;
   localparam int NRM_STEPS = FRAC_BITS + 1;
   localparam int NRM_PER   = 4;
   localparam int NRM_ST    = (NRM_STEPS + NRM_PER - 1) / NRM_PER;

   // Register file
   localparam int CSR_AW = 5;
   localparam int CSR_N  = 7;

   typedef enum logic [2:0] {
      CSR_START_X,
      CSR_START_Y,
      CSR_START_Z,
      CSR_END_X,
      CSR_END_Y,
      CSR_END_Z,
      CSR_PULL
   } csr_index_type;

   // Data riding alongside the square root
   typedef struct packed {
      logic [LANES-1:0][CW-1:0]  vel;
      logic [DTW-1:0]            dt;
      logic [LANES-1:0]          neg;
      logic [LANES-1:0][RMW-1:0] rmag;
      logic                      attract;
   } sq_side_type;

endpackage

/* design/plat_sqrt.sv */
module plat_sqrt (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   output logic                  in_ready,
   input  logic [plat_pkg::R2W-1:0] in_x,
   input  plat_pkg::sq_side_type in_side,
   output logic                  out_valid,
   input  logic                  out_ready,
   output logic [plat_pkg::SQW-1:0] out_root,
   output plat_pkg::sq_side_type out_side
);

   localparam int NS  = plat_pkg::SQ_ST;
   localparam int PER = plat_pkg::SQ_PER;
   localparam int XW  = plat_pkg::R2W;
   localparam int QW  = plat_pkg::SQW;
   localparam int MW  = plat_pkg::SRW;

   logic                  v_ff    [NS];
   logic [XW-1:0]         x_ff    [NS];
   logic [MW-1:0]         rem_ff  [NS];
   logic [QW-1:0]         root_ff [NS];
   plat_pkg::sq_side_type side_ff [NS];
   logic                  rdy     [NS+1];

   assign rdy[NS] = out_ready;

   for (genvar k = 0; k < NS; k++) begin : g_stage
      logic                  src_v;
      logic [XW-1:0]         src_x;
      logic [MW-1:0]         src_rem;
      logic [QW-1:0]         src_root;
      plat_pkg::sq_side_type src_side;
      logic [XW-1:0]         x_in;
      logic [MW-1:0]         rem_in;
      logic [QW-1:0]         root_in;

      if (k == 0) begin : g_first
         assign src_v    = in_valid;
         assign src_x    = in_x;
         assign src_rem  = '0;
         assign src_root = '0;
         assign src_side = in_side;
      end else begin : g_next
         assign src_v    = v_ff[k-1];
         assign src_x    = x_ff[k-1];
         assign src_rem  = rem_ff[k-1];
         assign src_root = root_ff[k-1];
         assign src_side = side_ff[k-1];
      end

      assign rdy[k] = !v_ff[k] || rdy[k+1];

      // one result bit per step: bring down two bits, try (root << 2) | 1
      always_comb begin
         logic [MW+1:0] rem2;
         logic [MW+1:0] trial;
         x_in    = src_x;
         rem_in  = src_rem;
         root_in = src_root;
         for (int j = 0; j < PER; j++) begin
            if (k * PER + j < QW) begin
               rem2  = {rem_in, x_in[XW-1 -: 2]};
               trial = (MW+2)'({root_in, 2'b01});
               if (rem2 >= trial) begin
                  rem_in  = MW'(rem2 - trial);
                  root_in = {root_in[QW-2:0], 1'b1};
               end else begin
                  rem_in  = MW'(rem2);
                  root_in = {root_in[QW-2:0], 1'b0};
               end
               x_in = {x_in[XW-3:0], 2'b00};
            end
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[k] <= 1'b0;
         end else if (rdy[k]) begin
            v_ff[k] <= src_v;
         end
      end

      always_ff @(posedge clock) begin
         if (rdy[k]) begin
            x_ff[k]    <= x_in;
            rem_ff[k]  <= rem_in;
            root_ff[k] <= root_in;
            side_ff[k] <= src_side;
         end
      end
   end

   assign in_ready  = rdy[0];
   assign out_valid = v_ff[NS-1];
   assign out_root  = root_ff[NS-1];
   assign out_side  = side_ff[NS-1];

endmodule

/* design/particle_line_attractor.sv */
// Channel  Direction  Handshake            Word
// req      in         req_valid/req_ready  pos_x/y/z, vel_x/y/z, time_step
// rsp      out        rsp_valid/rsp_ready  new_vel_x/y/z, attracted
// csr      in         psel/penable/pwrite  7 x 32-bit registers at 4*index
//
// One word is taken per cycle while req_ready is high; every word passes 29
// register stages (4 set-up stages, 4 projection divider stages, 4 offset stages,
// 9 square root stages, 5 direction divider stages, 3 output stages).
// The square root, which resolves four bits per stage, has the most stages.
// Reset (synchronous) empties the pipe and clears the register file to zero;
// the data registers are not reset.
// Each stage holds only while it is full and the stage after it holds, so a
// rsp stall fills bubbles first and req_ready drops only when the pipe is full.
module particle_line_attractor (
   input  logic                          clock,
   input  logic                          reset,
   // particle in
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic signed [31:0]            req_pos_x,
   input  logic signed [31:0]            req_pos_y,
   input  logic signed [31:0]            req_pos_z,
   input  logic signed [31:0]            req_vel_x,
   input  logic signed [31:0]            req_vel_y,
   input  logic signed [31:0]            req_vel_z,
   input  logic [30:0]                   req_time_step,
   // updated velocity out
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic signed [31:0]            rsp_new_vel_x,
   output logic signed [31:0]            rsp_new_vel_y,
   output logic signed [31:0]            rsp_new_vel_z,
   output logic                          rsp_attracted,
   // register port
   input  logic                          psel,
   input  logic                          penable,
   input  logic                          pwrite,
   input  logic [plat_pkg::CSR_AW-1:0]   paddr,
   input  logic [31:0]                   pwdata,
   output logic [31:0]                   prdata,
   output logic                          pready
);

   localparam int L    = plat_pkg::LANES;
   localparam int F    = plat_pkg::FRAC_BITS;
   localparam int CW   = plat_pkg::CW;
   localparam int DW   = plat_pkg::DW;
   localparam int DTW  = plat_pkg::DTW;
   localparam int PW   = plat_pkg::PW;
   localparam int DOTW = plat_pkg::DOTW;
   localparam int LENW = plat_pkg::LENW;
   localparam int TRW  = plat_pkg::TRW;
   localparam int TW   = plat_pkg::TW;
   localparam int FPW  = plat_pkg::FPW;
   localparam int RW   = plat_pkg::RW;
   localparam int RMW  = plat_pkg::RMW;
   localparam int R2W  = plat_pkg::R2W;
   localparam int SQW  = plat_pkg::SQW;
   localparam int NRW  = plat_pkg::NRW;
   localparam int UW   = plat_pkg::UW;
   localparam int APW  = plat_pkg::APW;
   localparam int AW   = plat_pkg::AW;
   localparam int DPW  = plat_pkg::DPW;
   localparam int DELW = plat_pkg::DELW;
   localparam int SUMW = plat_pkg::SUMW;
   localparam int ND   = plat_pkg::DIVT_ST;
   localparam int NN   = plat_pkg::NRM_ST;

   // ------------------------------------------------------------------
   // Register file
   // ------------------------------------------------------------------
   logic signed [CW-1:0] cfg_ff [plat_pkg::CSR_N];
   logic [2:0]           csr_idx;

   assign pready  = 1'b1;
   assign csr_idx = paddr[plat_pkg::CSR_AW-1:2];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < plat_pkg::CSR_N; i++) begin
            cfg_ff[i] <= '0;
         end
      end else if (psel && penable && pwrite && pready) begin
         // drop writes beyond the last register
         if (csr_idx <= 3'(plat_pkg::CSR_PULL)) begin
            cfg_ff[csr_idx] <= pwdata;
         end
      end
   end

   always_comb begin
      unique case (plat_pkg::csr_index_type'(csr_idx))
         plat_pkg::CSR_START_X: prdata = cfg_ff[plat_pkg::CSR_START_X];
         plat_pkg::CSR_START_Y: prdata = cfg_ff[plat_pkg::CSR_START_Y];
         plat_pkg::CSR_START_Z: prdata = cfg_ff[plat_pkg::CSR_START_Z];
         plat_pkg::CSR_END_X:   prdata = cfg_ff[plat_pkg::CSR_END_X];
         plat_pkg::CSR_END_Y:   prdata = cfg_ff[plat_pkg::CSR_END_Y];
         plat_pkg::CSR_END_Z:   prdata = cfg_ff[plat_pkg::CSR_END_Z];
         plat_pkg::CSR_PULL:    prdata = cfg_ff[plat_pkg::CSR_PULL];
         default:               prdata = '0;
      endcase
   end

   // ------------------------------------------------------------------
   // Stall chain: a stage loads when it is empty or the next one loads
   // ------------------------------------------------------------------
   logic rdy_a, rdy_b, rdy_c, rdy_d, rdy_f, rdy_g, rdy_h, rdy_i;
   logic rdy_k, rdy_l, rdy_m;
   logic e_rdy [ND];
   logic n_rdy [NN];
   logic sq_in_ready;

   // ------------------------------------------------------------------
   // Stage A: vectors relative to the segment start
   // ------------------------------------------------------------------
   logic                    a_v_ff;
   logic signed [DW-1:0]    a_d_ff [L], a_d_in [L];
   logic signed [DW-1:0]    a_w_ff [L], a_w_in [L];
   logic signed [CW-1:0]    a_vel_ff [L], req_vel [L];
   logic signed [CW-1:0]    req_pos [L];
   logic [DTW-1:0]          a_dt_ff;

   assign req_pos = '{req_pos_x, req_pos_y, req_pos_z};
   assign req_vel = '{req_vel_x, req_vel_y, req_vel_z};
   assign req_ready = rdy_a;
   assign rdy_a = !a_v_ff || rdy_b;

   always_comb begin
      for (int i = 0; i < L; i++) begin
         a_d_in[i] = DW'(cfg_ff[int'(plat_pkg::CSR_END_X) + i])
                   - DW'(cfg_ff[int'(plat_pkg::CSR_START_X) + i]);
         a_w_in[i] = DW'(req_pos[i]) - DW'(cfg_ff[int'(plat_pkg::CSR_START_X) + i]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_v_ff <= 1'b0;
      end else if (rdy_a) begin
         a_v_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (rdy_a) begin
         a_d_ff   <= a_d_in;
         a_w_ff   <= a_w_in;
         a_vel_ff <= req_vel;
         a_dt_ff  <= req_time_step;
      end
   end

   // ------------------------------------------------------------------
   // Stage B: per-axis products for w.d and d.d
   // ------------------------------------------------------------------
   logic                 b_v_ff;
   logic signed [PW-1:0] b_dw_ff [L], b_dw_in [L];
   logic signed [PW-1:0] b_dd_ff [L], b_dd_in [L];
   logic signed [DW-1:0] b_d_ff [L], b_w_ff [L];
   logic signed [CW-1:0] b_vel_ff [L];
   logic [DTW-1:0]       b_dt_ff;

   assign rdy_b = !b_v_ff || rdy_c;

   always_comb begin
      for (int i = 0; i < L; i++) begin
         b_dw_in[i] = a_d_ff[i] * a_w_ff[i];
         b_dd_in[i] = a_d_ff[i] * a_d_ff[i];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b_v_ff <= 1'b0;
      end else if (rdy_b) begin
         b_v_ff <= a_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (rdy_b) begin
         b_dw_ff  <= b_dw_in;
         b_dd_ff  <= b_dd_in;
         b_d_ff   <= a_d_ff;
         b_w_ff   <= a_w_ff;
         b_vel_ff <= a_vel_ff;
         b_dt_ff  <= a_dt_ff;
      end
   end

   // ------------------------------------------------------------------
   // Stage C: dot product and squared length
   // ------------------------------------------------------------------
   logic                   c_v_ff;
   logic signed [DOTW-1:0] c_dot_ff, c_dot_in;
   logic [LENW-1:0]        c_len_ff, c_len_in;
   logic signed [DW-1:0]   c_d_ff [L], c_w_ff [L];
   logic signed [CW-1:0]   c_vel_ff [L];
   logic [DTW-1:0]         c_dt_ff;

   assign rdy_c = !c_v_ff || rdy_d;

   always_comb begin
      c_dot_in = '0;
      c_len_in = '0;
      for (int i = 0; i < L; i++) begin
         c_dot_in = c_dot_in + DOTW'(b_dw_ff[i]);
         c_len_in = c_len_in + LENW'(b_dd_ff[i]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         c_v_ff <= 1'b0;
      end else if (rdy_c) begin
         c_v_ff <= b_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (rdy_c) begin
         c_dot_ff <= c_dot_in;
         c_len_ff <= c_len_in;
         c_d_ff   <= b_d_ff;
         c_w_ff   <= b_w_ff;
         c_vel_ff <= b_vel_ff;
         c_dt_ff  <= b_dt_ff;
      end
   end

   // ------------------------------------------------------------------
   // Stage D: classify the projection (before start, past end, inside)
   // ------------------------------------------------------------------
   logic                 d_v_ff;
   logic                 d_pos_ff, d_ge_ff;
   logic [TRW-1:0]       d_rem_ff;
   logic [LENW-1:0]      d_len_ff;
   logic signed [DW-1:0] d_d_ff [L], d_w_ff [L];
   logic signed [CW-1:0] d_vel_ff [L];
   logic [DTW-1:0]       d_dt_ff;

   assign rdy_d = !d_v_ff || e_rdy[0];

   always_ff @(posedge clock) begin
      if (reset) begin
         d_v_ff <= 1'b0;
      end else if (rdy_d) begin
         d_v_ff <= c_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (rdy_d) begin
         d_pos_ff <= c_dot_ff > 0;
         d_ge_ff  <= c_dot_ff >= $signed(DOTW'(c_len_ff));
         d_rem_ff <= c_dot_ff[TRW-1:0];
         d_len_ff <= c_len_ff;
         d_d_ff   <= c_d_ff;
         d_w_ff   <= c_w_ff;
         d_vel_ff <= c_vel_ff;
         d_dt_ff  <= c_dt_ff;
      end
   end

   // ------------------------------------------------------------------
   // Stages E: restoring divide dot * ONE / len2, only used for 0 < dot < len2
   // ------------------------------------------------------------------
   logic                 e_v_ff   [ND];
   logic                 e_pos_ff [ND], e_ge_ff [ND];
   logic [TRW-1:0]       e_rem_ff [ND];
   logic [F-1:0]         e_q_ff   [ND];
   logic [LENW-1:0]      e_len_ff [ND];
   logic signed [DW-1:0] e_d_ff   [ND][L];
   logic signed [DW-1:0] e_w_ff   [ND][L];
   logic signed [CW-1:0] e_vel_ff [ND][L];
   logic [DTW-1:0]       e_dt_ff  [ND];

   for (genvar k = 0; k < ND; k++) begin : g_tdiv
      logic                 src_v, src_pos, src_ge;
      logic [TRW-1:0]       src_rem, rem_in;
      logic [F-1:0]         src_q, q_in;
      logic [LENW-1:0]      src_len;
      logic signed [DW-1:0] src_d [L], src_w [L];
      logic signed [CW-1:0] src_vel [L];
      logic [DTW-1:0]       src_dt;

      if (k == 0) begin : g_first
         assign src_v   = d_v_ff;
         assign src_pos = d_pos_ff;
         assign src_ge  = d_ge_ff;
         assign src_rem = d_rem_ff;
         assign src_q   = '0;
         assign src_len = d_len_ff;
         assign src_d   = d_d_ff;
         assign src_w   = d_w_ff;
         assign src_vel = d_vel_ff;
         assign src_dt  = d_dt_ff;
      end else begin : g_next
         assign src_v   = e_v_ff[k-1];
         assign src_pos = e_pos_ff[k-1];
         assign src_ge  = e_ge_ff[k-1];
         assign src_rem = e_rem_ff[k-1];
         assign src_q   = e_q_ff[k-1];
         assign src_len = e_len_ff[k-1];
         assign src_d   = e_d_ff[k-1];
         assign src_w   = e_w_ff[k-1];
         assign src_vel = e_vel_ff[k-1];
         assign src_dt  = e_dt_ff[k-1];
      end

      if (k == ND - 1) begin : g_last
         assign e_rdy[k] = !e_v_ff[k] || rdy_f;
      end else begin : g_mid
         assign e_rdy[k] = !e_v_ff[k] || e_rdy[k+1];
      end

      always_comb begin
         rem_in = src_rem;
         q_in   = src_q;
         for (int j = 0; j < plat_pkg::DIVT_PER; j++) begin
            if (k * plat_pkg::DIVT_PER + j < F) begin
               rem_in = {rem_in[TRW-2:0], 1'b0};
               q_in   = {q_in[F-2:0], 1'b0};
               if (rem_in >= TRW'(src_len)) begin
                  rem_in  = rem_in - TRW'(src_len);
                  q_in[0] = 1'b1;
               end
            end
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            e_v_ff[k] <= 1'b0;
         end else if (e_rdy[k]) begin
            e_v_ff[k] <= src_v;
         end
      end

      always_ff @(posedge clock) begin
         if (e_rdy[k]) begin
            e_pos_ff[k] <= src_pos;
            e_ge_ff[k]  <= src_ge;
            e_rem_ff[k] <= rem_in;
            e_q_ff[k]   <= q_in;
            e_len_ff[k] <= src_len;
            e_d_ff[k]   <= src_d;
            e_w_ff[k]   <= src_w;
            e_vel_ff[k] <= src_vel;
            e_dt_ff[k]  <= src_dt;
         end
      end
   end

   // ------------------------------------------------------------------
   // Stage F: clamp t to 0..ONE and scale the segment by it
   // ------------------------------------------------------------------
   logic                  f_v_ff;
   logic [TW-1:0]         f_t;
   logic signed [FPW-1:0] f_p_ff [L], f_p_in [L];
   logic signed [DW-1:0]  f_w_ff [L];
   logic signed [CW-1:0]  f_vel_ff [L];
   logic [DTW-1:0]        f_dt_ff;

   assign rdy_f = !f_v_ff || rdy_g;

   always_comb begin
      if (!e_pos_ff[ND-1]) begin
         f_t = '0;
      end else if (e_ge_ff[ND-1]) begin
         f_t = plat_pkg::T_ONE;
      end else begin
         f_t = TW'(e_q_ff[ND-1]);
      end
      for (int i = 0; i < L; i++) begin
         f_p_in[i] = e_d_ff[ND-1][i] * $signed({1'b0, f_t});
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         f_v_ff <= 1'b0;
      end else if (rdy_f) begin
         f_v_ff <= e_v_ff[ND-1];
      end
   end

   always_ff @(posedge clock) begin
      if (rdy_f) begin
         f_p_ff   <= f_p_in;
         f_w_ff   <= e_w_ff[ND-1];
         f_vel_ff <= e_vel_ff[ND-1];
         f_dt_ff  <= e_dt_ff[ND-1];
      end
   end

   // ------------------------------------------------------------------
   // Stage G: offset from the particle to the closest point
   // ------------------------------------------------------------------
   logic                 g_v_ff;
   logic signed [RW-1:0] g_r_ff [L], g_r_in [L];
   logic signed [CW-1:0] g_vel_ff [L];
   logic [DTW-1:0]       g_dt_ff;

   assign rdy_g = !g_v_ff || rdy_h;

   always_comb begin
      for (int i = 0; i < L; i++) begin
         // floor of d*t / ONE is the arithmetic top slice
         g_r_in[i] = RW'($signed(f_p_ff[i][FPW-1:F]) - f_w_ff[i]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         g_v_ff <= 1'b0;
      end else if (rdy_g) begin
         g_v_ff <= f_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (rdy_g) begin
         g_r_ff   <= g_r_in;
         g_vel_ff <= f_vel_ff;
         g_dt_ff  <= f_dt_ff;
      end
   end

   // ------------------------------------------------------------------
   // Stage H: magnitudes and their squares
   // ------------------------------------------------------------------
   logic                   h_v_ff;
   logic [L-1:0]           h_neg_ff, h_neg_in;
   logic [RMW-1:0]         h_mag_ff [L], h_mag_in [L];
   logic [2*RMW-1:0]       h_sq_ff  [L], h_sq_in  [L];
   logic signed [CW-1:0]   h_vel_ff [L];
   logic [DTW-1:0]         h_dt_ff;

   assign rdy_h = !h_v_ff || rdy_i;

   always_comb begin
      for (int i = 0; i < L; i++) begin
         h_neg_in[i] = g_r_ff[i] < 0;
         h_mag_in[i] = h_neg_in[i] ? RMW'(-g_r_ff[i]) : RMW'(g_r_ff[i]);
         h_sq_in[i]  = h_mag_in[i] * h_mag_in[i];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         h_v_ff <= 1'b0;
      end else if (rdy_h) begin
         h_v_ff <= g_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (rdy_h) begin
         h_neg_ff <= h_neg_in;
         h_mag_ff <= h_mag_in;
         h_sq_ff  <= h_sq_in;
         h_vel_ff <= g_vel_ff;
         h_dt_ff  <= g_dt_ff;
      end
   end

   // ------------------------------------------------------------------
   // Stage I: squared distance and the threshold test
   // ------------------------------------------------------------------
   logic                  i_v_ff;
   logic [R2W-1:0]        i_r2_ff, i_r2_in;
   plat_pkg::sq_side_type i_side_ff, i_side_in;

   assign rdy_i = !i_v_ff || sq_in_ready;

   always_comb begin
      i_r2_in = '0;
      for (int i = 0; i < L; i++) begin
         i_r2_in = i_r2_in + R2W'(h_sq_ff[i]);
      end
      for (int i = 0; i < L; i++) begin
         i_side_in.vel[i]  = h_vel_ff[i];
         i_side_in.rmag[i] = h_mag_ff[i];
      end
      i_side_in.dt      = h_dt_ff;
      i_side_in.neg     = h_neg_ff;
      i_side_in.attract = i_r2_in > plat_pkg::TH2;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         i_v_ff <= 1'b0;
      end else if (rdy_i) begin
         i_v_ff <= h_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (rdy_i) begin
         i_r2_ff   <= i_r2_in;
         i_side_ff <= i_side_in;
      end
   end

   // ------------------------------------------------------------------
   // Square root: distance = floor(sqrt(r.r))
   // ------------------------------------------------------------------
   logic                  sq_out_valid;
   logic [SQW-1:0]        sq_out_root;
   plat_pkg::sq_side_type sq_out_side;

   plat_sqrt u_sqrt (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (i_v_ff),
      .in_ready  (sq_in_ready),
      .in_x      (i_r2_ff),
      .in_side   (i_side_ff),
      .out_valid (sq_out_valid),
      .out_ready (n_rdy[0]),
      .out_root  (sq_out_root),
      .out_side  (sq_out_side)
   );

   // ------------------------------------------------------------------
   // Stages N: unit direction |r_i| * ONE / dist, three lanes in step.
   // |r_i| never exceeds dist, so the first step only decides the ONE bit.
   // ------------------------------------------------------------------
   logic                  n_v_ff    [NN];
   logic [NRW-1:0]        n_rem_ff  [NN][L];
   logic [TW-1:0]         n_q_ff    [NN][L];
   logic [SQW-1:0]        n_dist_ff [NN];
   plat_pkg::sq_side_type n_side_ff [NN];

   for (genvar k = 0; k < NN; k++) begin : g_norm
      logic                  src_v;
      logic [NRW-1:0]        src_rem [L], rem_in [L];
      logic [TW-1:0]         src_q [L], q_in [L];
      logic [SQW-1:0]        src_dist;
      plat_pkg::sq_side_type src_side;

      if (k == 0) begin : g_first
         assign src_v    = sq_out_valid;
         assign src_dist = sq_out_root;
         assign src_side = sq_out_side;
         for (genvar i = 0; i < L; i++) begin : g_lane
            assign src_rem[i] = NRW'(sq_out_side.rmag[i]);
            assign src_q[i]   = '0;
         end
      end else begin : g_next
         assign src_v    = n_v_ff[k-1];
         assign src_rem  = n_rem_ff[k-1];
         assign src_q    = n_q_ff[k-1];
         assign src_dist = n_dist_ff[k-1];
         assign src_side = n_side_ff[k-1];
      end

      if (k == NN - 1) begin : g_last
         assign n_rdy[k] = !n_v_ff[k] || rdy_k;
      end else begin : g_mid
         assign n_rdy[k] = !n_v_ff[k] || n_rdy[k+1];
      end

      always_comb begin
         rem_in = src_rem;
         q_in   = src_q;
         for (int i = 0; i < L; i++) begin
            for (int j = 0; j < plat_pkg::NRM_PER; j++) begin
               if (k * plat_pkg::NRM_PER + j < plat_pkg::NRM_STEPS) begin
                  if (k * plat_pkg::NRM_PER + j != 0) begin
                     rem_in[i] = {rem_in[i][NRW-2:0], 1'b0};
                  end
                  q_in[i] = {q_in[i][TW-2:0], 1'b0};
                  if (rem_in[i] >= NRW'(src_dist)) begin
                     rem_in[i]  = rem_in[i] - NRW'(src_dist);
                     q_in[i][0] = 1'b1;
                  end
               end
            end
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            n_v_ff[k] <= 1'b0;
         end else if (n_rdy[k]) begin
            n_v_ff[k] <= src_v;
         end
      end

      always_ff @(posedge clock) begin
         if (n_rdy[k]) begin
            n_rem_ff[k]  <= rem_in;
            n_q_ff[k]    <= q_in;
            n_dist_ff[k] <= src_dist;
            n_side_ff[k] <= src_side;
         end
      end
   end

   // ------------------------------------------------------------------
   // Stage K: signed unit direction times pull strength
   // ------------------------------------------------------------------
   logic                  k_v_ff;
   logic [TW-1:0]         k_q [L];
   logic signed [UW-1:0]  k_u [L];
   logic signed [APW-1:0] k_p [L];
   logic signed [AW-1:0]  k_a_ff [L], k_a_in [L];
   plat_pkg::sq_side_type k_side_ff;

   assign rdy_k = !k_v_ff || rdy_l;

   always_comb begin
      for (int i = 0; i < L; i++) begin
         k_q[i] = (n_q_ff[NN-1][i] > plat_pkg::T_ONE) ? plat_pkg::T_ONE : n_q_ff[NN-1][i];
         k_u[i] = n_side_ff[NN-1].neg[i] ? -$signed(UW'(k_q[i])) : $signed(UW'(k_q[i]));
         k_p[i] = k_u[i] * cfg_ff[plat_pkg::CSR_PULL];
         k_a_in[i] = AW'(k_p[i][APW-1:F]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         k_v_ff <= 1'b0;
      end else if (rdy_k) begin
         k_v_ff <= n_v_ff[NN-1];
      end
   end

   always_ff @(posedge clock) begin
      if (rdy_k) begin
         k_a_ff    <= k_a_in;
         k_side_ff <= n_side_ff[NN-1];
      end
   end

   // ------------------------------------------------------------------
   // Stage L: acceleration times time step
   // ------------------------------------------------------------------
   logic                   l_v_ff;
   logic signed [DPW-1:0]  l_p [L];
   logic signed [DELW-1:0] l_del_ff [L], l_del_in [L];
   plat_pkg::sq_side_type  l_side_ff;

   assign rdy_l = !l_v_ff || rdy_m;

   always_comb begin
      for (int i = 0; i < L; i++) begin
         l_p[i]      = k_a_ff[i] * $signed({1'b0, k_side_ff.dt});
         l_del_in[i] = l_p[i][DPW-1:F];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         l_v_ff <= 1'b0;
      end else if (rdy_l) begin
         l_v_ff <= k_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (rdy_l) begin
         l_del_ff  <= l_del_in;
         l_side_ff <= k_side_ff;
      end
   end

   // ------------------------------------------------------------------
   // Stage M: saturating velocity update, output register
   // ------------------------------------------------------------------
   logic                   m_v_ff;
   logic signed [SUMW-1:0] m_sum [L];
   logic signed [CW-1:0]   m_sat [L];
   logic signed [CW-1:0]   m_vel_ff [L], m_vel_in [L];
   logic                   m_att_ff;

   assign rdy_m = !m_v_ff || rsp_ready;

   always_comb begin
      for (int i = 0; i < L; i++) begin
         m_sum[i] = SUMW'($signed(l_side_ff.vel[i])) + SUMW'(l_del_ff[i]);
         // clip when the bits above the sign of a 32-bit word disagree
         if (m_sum[i][SUMW-1:CW-1] == '0 || m_sum[i][SUMW-1:CW-1] == '1) begin
            m_sat[i] = m_sum[i][CW-1:0];
         end else if (m_sum[i][SUMW-1]) begin
            m_sat[i] = {1'b1, {(CW-1){1'b0}}};
         end else begin
            m_sat[i] = {1'b0, {(CW-1){1'b1}}};
         end
         m_vel_in[i] = l_side_ff.attract ? m_sat[i] : $signed(l_side_ff.vel[i]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         m_v_ff <= 1'b0;
      end else if (rdy_m) begin
         m_v_ff <= l_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (rdy_m) begin
         m_vel_ff <= m_vel_in;
         m_att_ff <= l_side_ff.attract;
      end
   end

   assign rsp_valid     = m_v_ff;
   assign rsp_new_vel_x = m_vel_ff[0];
   assign rsp_new_vel_y = m_vel_ff[1];
   assign rsp_new_vel_z = m_vel_ff[2];
   assign rsp_attracted = m_att_ff;

`ifndef NO_ASSERTIONS
   // an accepted word must occupy the first stage on the next edge
   a_accept_enters: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> a_v_ff)
      else $error("accepted word did not enter the pipe");

   // beyond the threshold the distance is far from zero
   a_dist_nonzero: assert property (@(posedge clock) disable iff (reset)
      sq_out_valid && sq_out_side.attract |-> sq_out_root != '0)
      else $error("zero distance for an attracted particle");

   // each direction component is at most ONE before the clamp
   a_unit_bound: assert property (@(posedge clock) disable iff (reset)
      n_v_ff[NN-1] && n_side_ff[NN-1].attract |->
         n_q_ff[NN-1][0] <= plat_pkg::T_ONE && n_q_ff[NN-1][1] <= plat_pkg::T_ONE
         && n_q_ff[NN-1][2] <= plat_pkg::T_ONE)
      else $error("unit direction component exceeds one");
`endif

endmodule

/* dv/line_pull_checker.sv */
`timescale 1ns / 1ps

module line_pull_checker (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   input  logic               req_ready,
   input  logic signed [31:0] req_pos_x,
   input  logic signed [31:0] req_pos_y,
   input  logic signed [31:0] req_pos_z,
   input  logic signed [31:0] req_vel_x,
   input  logic signed [31:0] req_vel_y,
   input  logic signed [31:0] req_vel_z,
   input  logic [30:0]        req_time_step,
   input  logic               rsp_valid,
   input  logic               rsp_ready,
   input  logic signed [31:0] rsp_new_vel_x,
   input  logic signed [31:0] rsp_new_vel_y,
   input  logic signed [31:0] rsp_new_vel_z,
   input  logic               rsp_attracted,
   input  logic               psel,
   input  logic               penable,
   input  logic               pwrite,
   input  logic [plat_pkg::CSR_AW-1:0] paddr,
   input  logic [31:0]        pwdata,
   input  logic               pready,
   output int                 fails,
   output int                 pending
);

   typedef struct {
      logic signed [31:0] vx;
      logic signed [31:0] vy;
      logic signed [31:0] vz;
      logic               att;
   } velocity_word_type;

   localparam logic signed [127:0] Q_ONE = 128'sd1 <<< plat_pkg::FRAC_BITS;
   localparam logic signed [127:0] Q_TH  = (Q_ONE + 5) / 10;

   logic [31:0]       segment_regs [plat_pkg::CSR_N];
   velocity_word_type expected_velocities [$];

   assign pending = expected_velocities.size();

   function automatic velocity_word_type pull_velocity(input logic signed [31:0] pos [3],
                                                       input logic signed [31:0] vel [3],
                                                       input logic [30:0] dt);
      logic signed [127:0] d [3];
      logic signed [127:0] w [3];
      logic signed [127:0] r [3];
      logic signed [127:0] dot, len2, r2, t, root_len, c, mr, q, u, a, delta, nv, pull;
      logic signed [31:0]  res [3];
      velocity_word_type   o;
      dot  = 0;
      len2 = 0;
      r2   = 0;
      pull = $signed(segment_regs[int'(plat_pkg::CSR_PULL)]);
      for (int i = 0; i < 3; i++) begin
         d[i] = $signed(segment_regs[int'(plat_pkg::CSR_END_X) + i])
                - $signed(segment_regs[int'(plat_pkg::CSR_START_X) + i]);
         w[i] = $signed(pos[i]) - $signed(segment_regs[int'(plat_pkg::CSR_START_X) + i]);
         dot  = dot + w[i] * d[i];
         len2 = len2 + d[i] * d[i];
      end
      // clamp the projection to the segment ends
      if (dot <= 0) t = 0;
      else if (dot >= len2) t = Q_ONE;
      else t = (dot <<< plat_pkg::FRAC_BITS) / len2;
      for (int i = 0; i < 3; i++) begin
         r[i] = ((d[i] * t) >>> plat_pkg::FRAC_BITS) - w[i];
         r2   = r2 + r[i] * r[i];
      end
      o.att = (r2 > Q_TH * Q_TH);
      root_len = 0;
      for (int b = 40; b >= 0; b--) begin
         c = root_len | (128'sd1 <<< b);
         if (c * c <= r2) root_len = c;
      end
      for (int i = 0; i < 3; i++) begin
         res[i] = vel[i];
         if (o.att) begin
            mr = (r[i] < 0) ? -r[i] : r[i];
            q  = (root_len != 0) ? (mr <<< plat_pkg::FRAC_BITS) / root_len : 0;
            if (q > Q_ONE) q = Q_ONE;
            u     = (r[i] < 0) ? -q : q;
            a     = (u * pull) >>> plat_pkg::FRAC_BITS;
            delta = (a * $signed({97'd0, dt})) >>> plat_pkg::FRAC_BITS;
            nv    = $signed(vel[i]) + delta;
            if (nv > 128'sd2147483647) nv = 128'sd2147483647;
            if (nv < -128'sd2147483648) nv = -128'sd2147483648;
            res[i] = nv[31:0];
         end
      end
      o.vx = res[0];
      o.vy = res[1];
      o.vz = res[2];
      return o;
   endfunction

   always @(posedge clock) begin
      logic signed [31:0] pos [3];
      logic signed [31:0] vel [3];
      velocity_word_type  exp_w;
      if (reset) begin
         for (int i = 0; i < plat_pkg::CSR_N; i++) segment_regs[i] = '0;
         expected_velocities.delete();
         fails = 0;
      end else begin
         if (psel && penable && pwrite && pready &&
             paddr[plat_pkg::CSR_AW-1:2] < plat_pkg::CSR_N)
            segment_regs[paddr[plat_pkg::CSR_AW-1:2]] = pwdata;
         if (req_valid && req_ready) begin
            pos = '{req_pos_x, req_pos_y, req_pos_z};
            vel = '{req_vel_x, req_vel_y, req_vel_z};
            expected_velocities.push_back(pull_velocity(pos, vel, req_time_step));
         end
         if (rsp_valid && rsp_ready) begin
            if (expected_velocities.size() == 0) begin
               fails++;
               if (fails <= 10) $display("unexpected word: vel %0d %0d %0d att %0b",
                                         rsp_new_vel_x, rsp_new_vel_y, rsp_new_vel_z,
                                         rsp_attracted);
            end else begin
               exp_w = expected_velocities.pop_front();
               if (exp_w.vx !== rsp_new_vel_x || exp_w.vy !== rsp_new_vel_y ||
                   exp_w.vz !== rsp_new_vel_z || exp_w.att !== rsp_attracted) begin
                  fails++;
                  if (fails <= 10)
                     $display("mismatch: exp %0d %0d %0d att %0b, got %0d %0d %0d att %0b",
                              exp_w.vx, exp_w.vy, exp_w.vz, exp_w.att, rsp_new_vel_x,
                              rsp_new_vel_y, rsp_new_vel_z, rsp_attracted);
               end
            end
         end
      end
   end

endmodule

/* dv/testbench.sv */
`timescale 1ns / 1ps

module testbench;

   localparam int CYCLE_LIMIT = 400000;

   logic               clock = 0;
   logic               reset = 1;
   logic               req_valid = 0;
   logic               req_ready;
   logic signed [31:0] req_pos_x = 0, req_pos_y = 0, req_pos_z = 0;
   logic signed [31:0] req_vel_x = 0, req_vel_y = 0, req_vel_z = 0;
   logic [30:0]        req_time_step = 0;
   logic               rsp_valid;
   logic               rsp_ready = 0;
   logic signed [31:0] rsp_new_vel_x, rsp_new_vel_y, rsp_new_vel_z;
   logic               rsp_attracted;
   logic               psel = 0, penable = 0, pwrite = 0;
   logic [plat_pkg::CSR_AW-1:0] paddr = 0;
   logic [31:0]        pwdata = 0;
   logic [31:0]        prdata;
   logic               pready;

   int  fails, pending;
   int  cycles = 0;
   int  words_sent = 0;
   int  settings_used = 0;
   bit  drain_free = 0;     // keep rsp_ready high throughout
   int  stall_left = 0;

   always #2 clock = ~clock;

   particle_line_attractor i_dut (.*);

   line_pull_checker i_checker (.*);

   // Generous ceiling: abandon the run if the block locks up
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

   // Result side: random stalls, mostly short, a few long, none while drain_free
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (drain_free) begin
         rsp_ready <= 1'b1;
      end else if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_ready  <= 1'b0;
      end else if ($urandom_range(0, 99) < 3) begin
         stall_left <= $urandom_range(10, 50);
         rsp_ready  <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(0, 3) != 0);
      end
   end

   // Write one register: setup cycle, then access cycle
   task automatic write_reg(input plat_pkg::csr_index_type idx, input logic [31:0] value);
      @(posedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= plat_pkg::CSR_AW'(int'(idx) * 4);
      pwdata  <= value;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
   endtask

   // Hold until the pipe has drained, then let the tail settle
   task automatic wait_drained();
      while (pending != 0) @(posedge clock);
      repeat (40) @(posedge clock);
   endtask

   task automatic load_segment(input logic [31:0] sx, sy, sz, ex, ey, ez, pull);
      // drop valid so nothing more enters while the registers change
      req_valid <= 1'b0;
      wait_drained();
      write_reg(plat_pkg::CSR_START_X, sx);
      write_reg(plat_pkg::CSR_START_Y, sy);
      write_reg(plat_pkg::CSR_START_Z, sz);
      write_reg(plat_pkg::CSR_END_X, ex);
      write_reg(plat_pkg::CSR_END_Y, ey);
      write_reg(plat_pkg::CSR_END_Z, ez);
      write_reg(plat_pkg::CSR_PULL, pull);
      settings_used++;
   endtask

   // Present one word and hold it until accepted; valid stays high afterwards
   task automatic send_word(input logic signed [31:0] px, py, pz, vx, vy, vz,
                            input logic [30:0] ts);
      req_valid     <= 1'b1;
      req_pos_x     <= px;
      req_pos_y     <= py;
      req_pos_z     <= pz;
      req_vel_x     <= vx;
      req_vel_y     <= vy;
      req_vel_z     <= vz;
      req_time_step <= ts;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      words_sent++;
   endtask

   // Sender gap: usually none, sometimes short, rarely long
   task automatic sender_gap();
      int g;
      int roll;
      roll = $urandom_range(0, 99);
      g = (roll < 60) ? 0 : (roll < 95) ? $urandom_range(1, 3) : $urandom_range(10, 40);
      if (g > 0) begin
         req_valid <= 1'b0;
         repeat (g) @(posedge clock);
      end
   endtask

   function automatic logic signed [31:0] near_value(input int span);
      return $signed($urandom_range(0, 2 * span)) - span;
   endfunction

   function automatic logic signed [31:0] any_value();
      int roll;
      roll = $urandom_range(0, 9);
      if (roll == 0) return 32'sh7fffffff;
      if (roll == 1) return 32'sh80000000;
      if (roll < 5) return $urandom;
      return near_value(1 << 20);
   endfunction

   task automatic random_words(input int count, input int span);
      logic [30:0] ts;
      for (int n = 0; n < count; n++) begin
         ts = ($urandom_range(0, 3) == 0) ? 31'($urandom) : 31'($urandom_range(0, 1 << 17));
         if ($urandom_range(0, 3) != 0)
            send_word(near_value(span), near_value(span), near_value(span),
                      any_value(), any_value(), any_value(), ts);
         else
            send_word(any_value(), any_value(), any_value(),
                      any_value(), any_value(), any_value(), ts);
         sender_gap();
      end
   endtask

   initial begin
      logic signed [31:0] smax, smin;
      smax = 32'sh7fffffff;
      smin = 32'sh80000000;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Reset registers: zero-length segment at the origin, no pull
      send_word(0, 0, 0, smax, smin, 0, 31'h7fffffff);
      send_word(32'sd6554, 0, 0, 5, -5, 7, 31'h10000);
      send_word(32'sd6553, 0, 0, 1, 2, 3, 31'h10000);

      // Unit segment along x, strong pull: within threshold, beyond each end, sideways
      load_segment(0, 0, 0, 32'h10000, 0, 0, 32'h40000);
      send_word(32'h8000, 0, 0, 1, 2, 3, 31'h10000);
      send_word(32'h8000, 32'sd6554, 0, 1, 2, 3, 31'h10000);
      send_word(32'h8000, 32'sd6555, 0, 1, 2, 3, 31'h10000);
      send_word(-32'sh30000, 0, 0, 0, 0, 0, 31'h10000);
      send_word(32'h50000, 32'h20000, -32'sh20000, 0, 0, 0, 31'h8000);
      send_word(smax, smax, smax, smax, smax, smax, 31'h7fffffff);
      send_word(smin, smin, smin, smin, smin, smin, 31'h7fffffff);
      send_word(32'h8000, 32'h40000, 0, 0, 0, 0, 0);

      // Widest segment and most negative pull: saturation both ways
      load_segment(smin, smin, smin, smax, smax, smax, 32'h80000000);
      send_word(smax, smin, 0, smax, smin, 0, 31'h7fffffff);
      send_word(smin, smax, smax, smin, smax, 0, 31'h7fffffff);
      send_word(0, 0, 0, 0, 0, 0, 31'h7fffffff);
      send_word(smax, smax, smin, -1, 1, 0, 31'h7fffffff);

      // Tiny pull of one unit: attracted, velocity changes only by rounding
      load_segment(0, 0, 0, 0, 32'h10000, 0, 1);
      send_word(32'h100000, 0, 0, 9, 9, 9, 31'h1);
      send_word(smin, smax, smin, 9, 9, 9, 31'h7fffffff);

      // Zero-length segment with maximum pull
      load_segment(32'h12345, -32'sh777, 32'h40000, 32'h12345, -32'sh777, 32'h40000,
                   32'h7fffffff);
      send_word(32'h12345, -32'sh777, 32'h40000, 4, 4, 4, 31'h7fffffff);
      send_word(0, 0, 0, smax, smin, smax, 31'h7fffffff);
      random_words(40, 1 << 18);

      // Random settings, mostly moderate segments, one phase with free drain
      for (int ph = 0; ph < 8; ph++) begin
         drain_free = (ph == 3);
         if (ph == 5)
            load_segment(any_value(), any_value(), any_value(), any_value(), any_value(),
                         any_value(), $urandom);
         else
            load_segment(near_value(1 << 19), near_value(1 << 19), near_value(1 << 19),
                         near_value(1 << 19), near_value(1 << 19), near_value(1 << 19),
                         ($urandom_range(0, 3) == 0) ? $urandom : near_value(1 << 20));
         random_words(50, 1 << 20);
      end
      drain_free = 0;

      req_valid <= 1'b0;
      wait_drained();
      repeat (20) @(posedge clock);

      $display("Sent %0d particle words over %0d segment settings, including zero-length",
               words_sent, settings_used);
      $display("and extreme segments, saturating pulls and random sender and receiver stalls.");
      if (fails == 0 && pending == 0) begin
         $display("PASS");
      end else begin
         if (pending != 0) $display("%0d expected words never arrived", pending);
         $display("FAIL");
      end
      $finish;
   end

endmodule

/* sim.f */
design/plat_pkg.sv
design/plat_sqrt.sv
design/particle_line_attractor.sv
dv/line_pull_checker.sv
dv/testbench.sv
